[rtl/cpq_pkg.sv]
// cpq_pkg: shared types and constants for the class priority request queue
// holds beat structs, command codes and the per-cell entry and control types
// no dependencies
package cpq_pkg;

    localparam int KEY_BITS   = 16;
    localparam int CLASS_BITS = 2;
    localparam int PRIO_BITS  = 16;
    localparam int CMD_BITS   = 3;
    localparam int COUNT_BITS = 5;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_ADD    = 3'd0,
        CMD_REMOVE = 3'd1,
        CMD_CHANGE = 3'd2,
        CMD_POP    = 3'd3,
        CMD_CLEAR  = 3'd4,
        CMD_QUERY  = 3'd5
    } cmd_e;

    typedef struct packed {
        logic [CMD_BITS-1:0]   command;
        logic [KEY_BITS-1:0]   req_key;
        logic [CLASS_BITS-1:0] req_class;
        logic [PRIO_BITS-1:0]  req_priority;
    } cmd_beat_t;

    typedef struct packed {
        logic                  removed;
        logic                  dropped;
        logic                  front_valid;
        logic [KEY_BITS-1:0]   front_key;
        logic [CLASS_BITS-1:0] front_class;
        logic [COUNT_BITS-1:0] entry_count;
    } result_beat_t;

    // one slot of the sorted chain
    typedef struct packed {
        logic                  valid;
        logic [KEY_BITS-1:0]   key;
        logic [CLASS_BITS-1:0] cls;
        logic [PRIO_BITS-1:0]  prio;
    } entry_t;

    // broadcast to every cell
    typedef struct packed {
        logic                  remove_en;
        logic                  insert_en;
        logic                  clear_en;
        logic                  pop;
        logic [KEY_BITS-1:0]   key;
        logic [CLASS_BITS-1:0] cls;
        logic [PRIO_BITS-1:0]  prio;
    } cell_ctrl_t;

    // per-cell compare results
    typedef struct packed {
        logic hit;
        logic chg;
        logic eq;
        logic ahead;
    } cell_flags_t;

endpackage

[rtl/cpq_cell.sv]
// cpq_cell: one slot of the sorted request chain
// compares against the broadcast request and clears, shifts left, shifts right or loads
// depends on cpq_pkg
module cpq_cell
    import cpq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cell_ctrl_t  ctrl,
    input  entry_t      left_entry,
    input  entry_t      right_entry,
    input  logic        rm_in,
    input  logic        ahead_in,
    output entry_t      entry,
    output logic        rm_out,
    output logic        ahead_out,
    output cell_flags_t flags
);

    entry_t entry_reg;
    entry_t entry_next;
    logic   hit;
    logic   ahead;

    // key match, disabled on pop where the chain head is forced instead
    assign hit = entry_reg.valid && !ctrl.pop && (entry_reg.key == ctrl.key);

    // this entry ranks ahead of the request
    assign ahead = entry_reg.valid &&
                   ((entry_reg.cls < ctrl.cls) ||
                    ((entry_reg.cls == ctrl.cls) && (entry_reg.prio > ctrl.prio)));

    assign rm_out    = rm_in | hit;
    assign ahead_out = ahead;

    assign flags.hit   = hit;
    assign flags.chg   = hit && (entry_reg.cls != ctrl.cls);
    assign flags.eq    = entry_reg.valid && (entry_reg.cls == ctrl.cls) &&
                         (entry_reg.prio == ctrl.prio);
    assign flags.ahead = ahead;

    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.clear_en)
        begin
            entry_next.valid = 1'b0;
        end
        else if (ctrl.remove_en && rm_out)
        begin
            entry_next = right_entry;
        end
        else if (ctrl.insert_en && !ahead)
        begin
            if (ahead_in)
            begin
                entry_next.valid = 1'b1;
                entry_next.key   = ctrl.key;
                entry_next.cls   = ctrl.cls;
                entry_next.prio  = ctrl.prio;
            end
            else
            begin
                entry_next = left_entry;
            end
        end
    end

    // only the valid bit needs a reset, the payload is ignored while invalid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg.valid <= 1'b0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

endmodule

[rtl/class_priority_request_queue.sv]
// class_priority_request_queue: sorted keyed request queue built as a chain of cells
// top level: command decode, two-phase sequencing, output register
// depends on cpq_pkg and cpq_cell
//
// usage
//   in channel  (in_valid/in_ready/in_data): one command beat, add, remove,
//     change class, pop front, clear or query
//   out channel (out_valid/out_ready/out_data): exactly one result beat per
//     command, carrying removed/dropped flags, the front entry and the count
//   a command runs in two phases: the accept cycle runs the remove phase (every
//   cell compares its key and the chain shifts left past the match), then the
//   insert phase runs (every cell compares class and priority and the chain
//   opens a slot) and writes the result register
//   the result appears on out_valid in the cycle after the insert phase; a new
//   command is accepted only once the insert phase of the last one has run
//   a stalled receiver holds the result register; the next command is still
//   accepted and its remove phase runs, its insert phase then waits until the
//   result register drains
//   reset empties the queue (all cell valid bits cleared) and the output
//   register; no clearing pass is needed
module class_priority_request_queue
    import cpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  cmd_beat_t    in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output result_beat_t out_data
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_INSERT = 2'b10
    } state_t;

    state_t       state_reg, state_next;
    cmd_beat_t    req_reg, req_next;
    logic         ins_pending_reg, ins_pending_next;
    logic         removed_reg, removed_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic         out_valid_reg, out_valid_next;
    result_beat_t out_data_reg, out_data_next;

    // chain wiring
    cell_ctrl_t   ctrl;
    entry_t       cell_entry [QUEUE_DEPTH];
    cell_flags_t  cell_flags [QUEUE_DEPTH];
    logic [QUEUE_DEPTH:0] rm_chain;
    logic [QUEUE_DEPTH:0] ahead_chain;
    logic [QUEUE_DEPTH-1:0] hit_vec, chg_vec, eq_vec, valid_vec;

    logic         accept;
    cmd_e         cmd;
    logic         any_hit, any_chg, any_eq, full;
    logic         is_add, is_remove, is_change, is_pop, is_clear;
    logic         change_eff;
    logic         do_write;
    logic         drop;
    logic         ins;
    logic         front_new;
    logic [CNT_W-1:0] count_after;
    logic [31:0]  count_wide;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign cmd      = cmd_e'(in_data.command);

    assign is_add    = (cmd == CMD_ADD);
    assign is_remove = (cmd == CMD_REMOVE);
    assign is_change = (cmd == CMD_CHANGE);
    assign is_pop    = (cmd == CMD_POP);
    assign is_clear  = (cmd == CMD_CLEAR);

    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            hit_vec[i]   = cell_flags[i].hit;
            chg_vec[i]   = cell_flags[i].chg;
            eq_vec[i]    = cell_flags[i].eq;
            valid_vec[i] = cell_entry[i].valid;
        end
    end

    assign any_hit = |hit_vec;
    assign any_chg = |chg_vec;
    assign any_eq  = |eq_vec;
    assign full    = valid_vec[QUEUE_DEPTH-1];

    // change class only acts when the key is held under another class
    assign change_eff = is_change && any_chg;

    // insert phase runs once the result register can take a new beat
    assign do_write  = (state_reg == ST_INSERT) && (!out_valid_reg || out_ready);
    assign drop      = ins_pending_reg && (full || any_eq);
    assign ins       = ins_pending_reg && !drop;
    assign front_new = ins && !cell_flags[0].ahead;

    // broadcast: request comes from the input beat in the remove phase,
    // from the held request in the insert phase
    always_comb
    begin
        ctrl = '0;
        if (state_reg == ST_IDLE)
        begin
            ctrl.key       = in_data.req_key;
            ctrl.cls       = in_data.req_class;
            ctrl.prio      = in_data.req_priority;
            ctrl.pop       = is_pop;
            ctrl.remove_en = accept && (is_add || is_remove || is_pop || change_eff);
            ctrl.clear_en  = accept && is_clear;
        end
        else
        begin
            ctrl.key       = req_reg.req_key;
            ctrl.cls       = req_reg.req_class;
            ctrl.prio      = req_reg.req_priority;
            ctrl.insert_en = do_write && ins;
        end
    end

    // chain ends: pop forces the head to shift, the head always may load
    assign rm_chain[0]    = ctrl.pop;
    assign ahead_chain[0] = 1'b1;

    for (genvar g = 0; g < QUEUE_DEPTH; g++)
    begin : g_cell
        entry_t left_entry;
        entry_t right_entry;

        if (g == 0)
        begin : g_head
            assign left_entry = '0;
        end
        else
        begin : g_body
            assign left_entry = cell_entry[g-1];
        end

        if (g == QUEUE_DEPTH - 1)
        begin : g_tail
            assign right_entry = '0;
        end
        else
        begin : g_mid
            assign right_entry = cell_entry[g+1];
        end

        cpq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .rm_in       (rm_chain[g]),
            .ahead_in    (ahead_chain[g]),
            .entry       (cell_entry[g]),
            .rm_out      (rm_chain[g+1]),
            .ahead_out   (ahead_chain[g+1]),
            .flags       (cell_flags[g])
        );
    end

    assign count_after = count_reg + {{(CNT_W-1){1'b0}}, ins};
    assign count_wide  = 32'(count_after);

    always_comb
    begin
        state_next       = state_reg;
        req_next         = req_reg;
        ins_pending_next = ins_pending_reg;
        removed_next     = removed_reg;
        count_next       = count_reg;
        out_valid_next   = out_valid_reg;
        out_data_next    = out_data_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    req_next         = in_data;
                    ins_pending_next = is_add || change_eff;
                    removed_next     = (is_add || is_remove || change_eff) && any_hit;
                    if (is_clear)
                    begin
                        count_next = '0;
                    end
                    else if (is_pop ? valid_vec[0] :
                             ((is_add || is_remove || change_eff) && any_hit))
                    begin
                        count_next = count_reg - {{(CNT_W-1){1'b0}}, 1'b1};
                    end
                    state_next = ST_INSERT;
                end
            end
            ST_INSERT:
            begin
                if (do_write)
                begin
                    count_next                = count_after;
                    out_valid_next            = 1'b1;
                    out_data_next.removed     = removed_reg;
                    out_data_next.dropped     = drop;
                    out_data_next.front_valid = (count_after != '0);
                    if (front_new)
                    begin
                        out_data_next.front_key   = req_reg.req_key;
                        out_data_next.front_class = req_reg.req_class;
                    end
                    else if (cell_entry[0].valid)
                    begin
                        out_data_next.front_key   = cell_entry[0].key;
                        out_data_next.front_class = cell_entry[0].cls;
                    end
                    else
                    begin
                        out_data_next.front_key   = '0;
                        out_data_next.front_class = '0;
                    end
                    out_data_next.entry_count = count_wide[COUNT_BITS-1:0];
                    state_next                = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            ins_pending_reg <= 1'b0;
            removed_reg     <= 1'b0;
            count_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            ins_pending_reg <= ins_pending_next;
            removed_reg     <= removed_next;
            count_reg       <= count_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // occupied cells always form a prefix of the chain
    a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        ((valid_vec >> 1) & ~valid_vec) == '0)
        else $error("valid cells not contiguous");

    // the count tracks the number of occupied cells
    a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == 32'(count_reg))
        else $error("entry count out of step with cell valid bits");

    // a result beat is only produced by the insert phase
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_INSERT))
        else $error("result beat raised outside the insert phase");

endmodule

[dv/tb_class_priority_request_queue.sv]
// testbench for class_priority_request_queue: directed, full-queue, random and backpressure tests
// predicts every result beat with a sorted-array model of the queue and checks it field by field
// depends on cpq_pkg and the class_priority_request_queue rtl
module tb_class_priority_request_queue
    import cpq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUEUE_DEPTH = 16;
    // codes outside the defined command set, handled as query only
    localparam logic [CMD_BITS-1:0] CMD_RSVD_A = 3'd6;
    localparam logic [CMD_BITS-1:0] CMD_RSVD_B = 3'd7;
    // cycles with no beat on either channel before the run is declared hung
    localparam int HANG_LIMIT = 3000;
    // length of the long receiver hold-off in the backpressure test
    localparam int HOLD_OFF_CYCLES = 300;

    logic         clk;
    logic         rst_n;
    logic         in_valid;
    logic         in_ready;
    cmd_beat_t    in_data;
    logic         out_valid;
    logic         out_ready;
    result_beat_t out_data;

    class_priority_request_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // queue predictor: slots 0..held_count-1 kept in rank order
    // ------------------------------------------------------------------
    logic [KEY_BITS-1:0]   held_key  [QUEUE_DEPTH];
    logic [CLASS_BITS-1:0] held_class[QUEUE_DEPTH];
    logic [PRIO_BITS-1:0]  held_prio [QUEUE_DEPTH];
    int                    held_count;

    // expected result beats, oldest first
    result_beat_t expected_results[$];

    // knobs shared between the test tasks and the channel processes
    bit sender_idles;
    bit receiver_idles;
    int hold_off_request;

    // bookkeeping
    int mismatches;
    int commands_sent;
    int results_seen;
    int removals_seen;
    int drops_seen;
    int full_results_seen;
    int input_stall_cycles;

    // close the gap left by slot pos, everything behind moves up one rank
    function automatic void close_slot(int pos);
        for (int i = pos; i + 1 < held_count; i++)
        begin
            held_key[i]   = held_key[i + 1];
            held_class[i] = held_class[i + 1];
            held_prio[i]  = held_prio[i + 1];
        end
        held_count--;
    endfunction

    // rank of key, or QUEUE_DEPTH when not held
    function automatic int locate_key(logic [KEY_BITS-1:0] key);
        for (int i = 0; i < held_count; i++)
            if (held_key[i] == key)
                return i;
        return QUEUE_DEPTH;
    endfunction

    function automatic bit purge_key(logic [KEY_BITS-1:0] key);
        bit any;
        int pos;
        any = 1'b0;
        pos = locate_key(key);
        while (pos < held_count)
        begin
            close_slot(pos);
            any = 1'b1;
            pos = locate_key(key);
        end
        return any;
    endfunction

    // returns 1 when the insert is rejected
    function automatic bit insert_ranked(logic [KEY_BITS-1:0] key,
                                         logic [CLASS_BITS-1:0] cls,
                                         logic [PRIO_BITS-1:0] prio);
        int pos;
        pos = 0;
        if (held_count >= QUEUE_DEPTH)
            return 1'b1;
        for (int i = 0; i < held_count; i++)
        begin
            // same class and priority already held: the ordered set refuses it
            if (held_class[i] == cls && held_prio[i] == prio)
                return 1'b1;
            if (held_class[i] < cls || (held_class[i] == cls && held_prio[i] > prio))
                pos = i + 1;
        end
        for (int i = held_count; i > pos; i--)
        begin
            held_key[i]   = held_key[i - 1];
            held_class[i] = held_class[i - 1];
            held_prio[i]  = held_prio[i - 1];
        end
        held_key[pos]   = key;
        held_class[pos] = cls;
        held_prio[pos]  = prio;
        held_count++;
        return 1'b0;
    endfunction

    // apply one command beat to the predicted queue and build its result beat
    function automatic result_beat_t apply_command(cmd_beat_t c);
        result_beat_t r;
        int           pos;
        r = '0;
        case (c.command)
            CMD_ADD:
            begin
                // removal of the old entry stands even when the insert is dropped
                r.removed = purge_key(c.req_key);
                r.dropped = insert_ranked(c.req_key, c.req_class, c.req_priority);
            end
            CMD_REMOVE:
                r.removed = purge_key(c.req_key);
            CMD_CHANGE:
            begin
                // only a held key moving to a different class is re-added
                pos = locate_key(c.req_key);
                if (pos < held_count && held_class[pos] != c.req_class)
                begin
                    r.removed = purge_key(c.req_key);
                    r.dropped = insert_ranked(c.req_key, c.req_class, c.req_priority);
                end
            end
            CMD_POP:
                if (held_count > 0)
                    close_slot(0);
            CMD_CLEAR:
                held_count = 0;
            default:
                ;   // query and unused codes leave the queue alone
        endcase
        r.front_valid = (held_count > 0);
        if (held_count > 0)
        begin
            r.front_key   = held_key[0];
            r.front_class = held_class[0];
        end
        r.entry_count = held_count[COUNT_BITS-1:0];
        return r;
    endfunction

    function automatic cmd_beat_t make_command(logic [CMD_BITS-1:0] cmd,
                                               logic [KEY_BITS-1:0] key,
                                               logic [CLASS_BITS-1:0] cls,
                                               logic [PRIO_BITS-1:0] prio);
        cmd_beat_t c;
        c.command      = cmd;
        c.req_key      = key;
        c.req_class    = cls;
        c.req_priority = prio;
        return c;
    endfunction

    // random command; keys and priorities mostly come from small pools so that
    // key hits and class/priority collisions are frequent
    function automatic cmd_beat_t random_command();
        cmd_beat_t c;
        int        pick;
        pick = $urandom_range(0, 99);
        if (pick < 42)
            c.command = CMD_ADD;
        else if (pick < 54)
            c.command = CMD_REMOVE;
        else if (pick < 70)
            c.command = CMD_CHANGE;
        else if (pick < 83)
            c.command = CMD_POP;
        else if (pick < 86)
            c.command = CMD_CLEAR;
        else if (pick < 94)
            c.command = CMD_QUERY;
        else if (pick < 97)
            c.command = CMD_RSVD_A;
        else
            c.command = CMD_RSVD_B;

        pick = $urandom_range(0, 99);
        if (pick < 75)
            c.req_key = KEY_BITS'($urandom_range(0, 23));
        else if (pick < 80)
            c.req_key = KEY_BITS'(16'hFFFF - $urandom_range(0, 3));
        else
            c.req_key = KEY_BITS'($urandom_range(0, 65535));

        c.req_class = CLASS_BITS'($urandom_range(0, 3));

        pick = $urandom_range(0, 99);
        if (pick < 60)
            c.req_priority = PRIO_BITS'($urandom_range(0, 7));
        else if (pick < 65)
            c.req_priority = 16'hFFFF;
        else
            c.req_priority = PRIO_BITS'($urandom_range(0, 65535));
        return c;
    endfunction

    // ------------------------------------------------------------------
    // sender: offer one command beat and wait until it is accepted
    // called at a rising edge, returns at the edge that accepted the beat
    // ------------------------------------------------------------------
    task automatic send_command(cmd_beat_t c);
        if (sender_idles && $urandom_range(0, 99) < 14)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= c;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_results.push_back(apply_command(c));
        commands_sent++;
    endtask

    // drop valid after the last beat and wait for every result to come back
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("[%0t] result %0d: %s is 0x%0h, expected 0x%0h",
                 $realtime, results_seen, field, got, want);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // receiver: check every accepted result beat, then pick the next ready
    // ------------------------------------------------------------------
    int hold_off_left;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("unexpected beat, front_key", out_data.front_key, '0);
            end
            else
            begin
                result_beat_t want;
                want = expected_results.pop_front();
                if (out_data.removed !== want.removed)
                    report_mismatch("removed", out_data.removed, want.removed);
                if (out_data.dropped !== want.dropped)
                    report_mismatch("dropped", out_data.dropped, want.dropped);
                if (out_data.front_valid !== want.front_valid)
                    report_mismatch("front_valid", out_data.front_valid, want.front_valid);
                if (out_data.front_key !== want.front_key)
                    report_mismatch("front_key", out_data.front_key, want.front_key);
                if (out_data.front_class !== want.front_class)
                    report_mismatch("front_class", out_data.front_class, want.front_class);
                if (out_data.entry_count !== want.entry_count)
                    report_mismatch("entry_count", out_data.entry_count, want.entry_count);
                if (want.removed)
                    removals_seen++;
                if (want.dropped)
                    drops_seen++;
                if (want.entry_count == COUNT_BITS'(QUEUE_DEPTH))
                    full_results_seen++;
            end
            results_seen++;
        end

        // long hold-off has priority over the random idling
        if (hold_off_left > 0)
        begin
            hold_off_left--;
            out_ready <= 1'b0;
        end
        else if (hold_off_request > 0)
        begin
            hold_off_left    = hold_off_request - 1;
            hold_off_request = 0;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= !(receiver_idles && $urandom_range(0, 99) < 14);
        end
    end

    // ------------------------------------------------------------------
    // watchdog: too many cycles with no beat on either channel ends the run
    // ------------------------------------------------------------------
    int quiet_cycles;

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (in_valid && !in_ready)
            input_stall_cycles++;
        if (quiet_cycles >= HANG_LIMIT)
        begin
            $display("[%0t] no beat accepted for %0d cycles", $realtime, HANG_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // extremes of every field, every command and the corner behaviors
    task automatic test_directed_cases();
        send_command(make_command(CMD_QUERY,  16'h0000, 2'd0, 16'h0000));  // empty queue
        send_command(make_command(CMD_POP,    16'h0000, 2'd0, 16'h0000));  // pop when empty
        send_command(make_command(CMD_REMOVE, 16'h0005, 2'd0, 16'h0000));  // key not held
        send_command(make_command(CMD_ADD,    16'h0000, 2'd3, 16'h0000));
        send_command(make_command(CMD_ADD,    16'hFFFF, 2'd0, 16'hFFFF));  // new front
        send_command(make_command(CMD_ADD,    16'h0001, 2'd0, 16'h0000));
        // same class and priority as key ffff: dropped
        send_command(make_command(CMD_ADD,    16'h0002, 2'd0, 16'hFFFF));
        // re-add a held key at a new place
        send_command(make_command(CMD_ADD,    16'h0001, 2'd2, 16'h0064));
        // re-add a key with its own class and priority: removed and put back
        send_command(make_command(CMD_ADD,    16'hFFFF, 2'd0, 16'hFFFF));
        // change to the class already held: no effect
        send_command(make_command(CMD_CHANGE, 16'h0001, 2'd2, 16'h0007));
        send_command(make_command(CMD_CHANGE, 16'h0001, 2'd1, 16'h0007));
        send_command(make_command(CMD_CHANGE, 16'h004D, 2'd3, 16'h0001));  // key not held
        // change that collides with key ffff: the entry stays removed
        send_command(make_command(CMD_CHANGE, 16'h0000, 2'd0, 16'hFFFF));
        send_command(make_command(CMD_RSVD_A, 16'hFFFF, 2'd3, 16'hFFFF));
        send_command(make_command(CMD_RSVD_B, 16'h0001, 2'd1, 16'h0007));
        send_command(make_command(CMD_REMOVE, 16'hFFFF, 2'd0, 16'h0000));
        send_command(make_command(CMD_POP,    16'h1234, 2'd2, 16'h0000));
        send_command(make_command(CMD_ADD,    16'h5555, 2'd1, 16'hAAAA));
        send_command(make_command(CMD_ADD,    16'hAAAA, 2'd1, 16'h5555));
        // add removes the old 5555 entry, then collides with aaaa
        send_command(make_command(CMD_ADD,    16'h5555, 2'd1, 16'h5555));
        send_command(make_command(CMD_CLEAR,  16'h0000, 2'd0, 16'h0000));
        send_command(make_command(CMD_QUERY,  16'hFFFF, 2'd3, 16'hFFFF));
        send_command(make_command(CMD_POP,    16'h0000, 2'd0, 16'h0000));  // empty after clear
        drain_results();
    endtask

    // fill to the depth limit, overflow it, then work on the full queue
    task automatic test_full_queue(int rounds);
        int base;
        for (int r = 0; r < rounds; r++)
        begin
            base = $urandom_range(0, 60000);
            send_command(make_command(CMD_CLEAR, '0, '0, '0));
            for (int i = 0; i < QUEUE_DEPTH; i++)
                send_command(make_command(CMD_ADD, KEY_BITS'(base + i),
                                          CLASS_BITS'($urandom_range(0, 3)),
                                          PRIO_BITS'(i * 3)));
            // full: a new key is dropped
            send_command(make_command(CMD_ADD, KEY_BITS'(base + QUEUE_DEPTH),
                                      CLASS_BITS'($urandom_range(0, 3)), 16'h7FFF));
            // full, but the key is held: it frees its own slot first
            send_command(make_command(CMD_ADD, KEY_BITS'(base + 5), 2'd3, 16'h8000));
            send_command(make_command(CMD_CHANGE, KEY_BITS'(base + 5), 2'd0, 16'h8001));
            send_command(make_command(CMD_POP, '0, '0, '0));
            send_command(make_command(CMD_QUERY, '0, '0, '0));
        end
        drain_results();
    endtask

    task automatic test_random_traffic(int count);
        repeat (count)
            send_command(random_command());
        drain_results();
    endtask

    // receiver holds off for a long stretch while commands keep coming,
    // so the result register stays held and the block stalls its input
    task automatic test_output_backpressure();
        hold_off_request = HOLD_OFF_CYCLES;
        repeat (40)
            send_command(random_command());
        drain_results();
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n            <= 1'b0;
        in_valid         <= 1'b0;
        in_data          <= '0;
        out_ready        <= 1'b0;
        held_count       = 0;
        sender_idles     = 1'b1;
        receiver_idles   = 1'b1;
        hold_off_request = 0;
        hold_off_left    = 0;
        quiet_cycles     = 0;
        mismatches       = 0;
        commands_sent    = 0;
        results_seen     = 0;
        removals_seen    = 0;
        drops_seen       = 0;
        full_results_seen  = 0;
        input_stall_cycles = 0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_full_queue(3);
        test_random_traffic(500);

        // stretch with no idling on either side: back-to-back beats
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        test_random_traffic(300);
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;

        test_output_backpressure();
        test_random_traffic(350);

        drain_results();
        repeat (6) @(posedge clk);

        $display("ran %0d commands and checked %0d results: %0d removals, %0d dropped inserts",
                 commands_sent, results_seen, removals_seen, drops_seen);
        $display("%0d results with a full queue, input stalled for %0d cycles",
                 full_results_seen, input_stall_cycles);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
